// ----- rtl/core/bfr_pkg.sv -----
package bfr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned INDEX_W     = 9;
	localparam int unsigned COUNT_W     = 12;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic [COUNT_W-1:0] MAX_COUNT = 12'd2048;
	localparam logic [INDEX_W-1:0] POS_MAX   = 9'd511;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRG_START  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRG_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 3'd4;

	typedef struct packed {
		logic [INDEX_W-1:0] trg_index;
		logic [BYTE_W-1:0]  trg_bits;
		logic [BYTE_W-1:0]  trg_mask;
		logic               is_last;
	} bfr_result_t;

	// One queue entry: the results caused by one source byte, oldest in res0.
	typedef struct packed {
		logic        two;
		bfr_result_t res0;
		bfr_result_t res1;
	} bfr_record_t;

endpackage

// ----- rtl/core/bfr_front.sv -----
module bfr_front import bfr_pkg::*; #(
	parameter int unsigned BUF_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  accept,
	input  logic [BYTE_W-1:0]     src_byte,
	input  logic                  frame_start,
	output logic                  rec_valid,
	output bfr_record_t           rec
);

	localparam logic [16:0] BUF_LIMIT = 17'(BUF_BYTES);

	logic [7:0]         src_start_q;
	logic [2:0]         src_offset_q;
	logic [7:0]         trg_start_q;
	logic [2:0]         trg_offset_q;
	logic [COUNT_W-1:0] bit_count_q;

	logic [INDEX_W-1:0] pos_q;
	logic [COUNT_W-1:0] rem_q;
	logic [BYTE_W-1:0]  acc_q;
	logic [BYTE_W-1:0]  mask_q;
	logic [2:0]         fill_q;
	logic [INDEX_W-1:0] nti_q;

	logic [INDEX_W-1:0] pos_c, pos_n;
	logic [COUNT_W-1:0] rem_c, rem_n;
	logic [BYTE_W-1:0]  acc_c, acc_n, mask_c, mask_n;
	logic [2:0]         fill_c, fill_n;
	logic [INDEX_W-1:0] nti_c, nti_n;

	logic               active;
	logic [2:0]         start;
	logic [3:0]         n;
	logic [BYTE_W-1:0]  vmask, val;
	logic [3:0]         total;
	logic [15:0]        comb, cmask;
	logic               emit_a, emit_b;
	bfr_result_t        res_a, res_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_start_q  <= '0;
			src_offset_q <= '0;
			trg_start_q  <= '0;
			trg_offset_q <= '0;
			bit_count_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SRC_START:  src_start_q  <= cfg_wdata[7:0];
				CFG_SRC_OFFSET: src_offset_q <= cfg_wdata[2:0];
				CFG_TRG_START:  trg_start_q  <= cfg_wdata[7:0];
				CFG_TRG_OFFSET: trg_offset_q <= cfg_wdata[2:0];
				CFG_BIT_COUNT:  bit_count_q  <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// frame start reloads the copy state before the byte is processed
		if (frame_start) begin
			pos_c  = '0;
			rem_c  = (bit_count_q > MAX_COUNT) ? MAX_COUNT : bit_count_q;
			acc_c  = '0;
			mask_c = '0;
			fill_c = trg_offset_q;
			nti_c  = {1'b0, trg_start_q};
		end else begin
			pos_c  = pos_q;
			rem_c  = rem_q;
			acc_c  = acc_q;
			mask_c = mask_q;
			fill_c = fill_q;
			nti_c  = nti_q;
		end

		pos_n = (pos_c < POS_MAX) ? pos_c + 9'd1 : pos_c;

		active = (rem_c != '0) && ({8'd0, pos_c} < BUF_LIMIT) &&
			(pos_c >= {1'b0, src_start_q});
		start  = (pos_c == {1'b0, src_start_q}) ? src_offset_q : 3'd0;
		n      = 4'd8 - {1'b0, start};
		if ({8'd0, n} > rem_c)
			n = rem_c[3:0];
		vmask  = 8'hFF >> (4'd8 - n);
		val    = (src_byte >> start) & vmask;
		total  = {1'b0, fill_c} + n;
		comb   = {8'd0, acc_c} | ({8'd0, val} << fill_c);
		cmask  = {8'd0, mask_c} | ({8'd0, vmask} << fill_c);

		rem_n  = rem_c;
		acc_n  = acc_c;
		mask_n = mask_c;
		fill_n = fill_c;
		nti_n  = nti_c;
		emit_a = 1'b0;
		emit_b = 1'b0;
		res_a  = '0;
		res_b  = '0;

		if (active) begin
			rem_n = rem_c - {8'd0, n};
			if (total >= 4'd8) begin
				emit_a          = 1'b1;
				res_a.trg_index = nti_c;
				res_a.trg_bits  = comb[7:0] & cmask[7:0];
				res_a.trg_mask  = cmask[7:0];
				res_a.is_last   = (rem_n == '0) && (total == 4'd8);
				nti_n           = nti_c + 9'd1;
				acc_n           = comb[15:8];
				mask_n          = cmask[15:8];
				fill_n          = total[2:0];
			end else begin
				acc_n  = comb[7:0];
				mask_n = cmask[7:0];
				fill_n = total[2:0];
			end
			// flush the partial final target byte
			if ((rem_n == '0) && (fill_n != 3'd0)) begin
				emit_b          = 1'b1;
				res_b.trg_index = nti_n;
				res_b.trg_bits  = acc_n & mask_n;
				res_b.trg_mask  = mask_n;
				res_b.is_last   = 1'b1;
				nti_n           = nti_n + 9'd1;
				acc_n           = '0;
				mask_n          = '0;
				fill_n          = 3'd0;
			end
		end

		rec_valid = accept && (emit_a || emit_b);
		rec.two   = emit_a && emit_b;
		rec.res0  = emit_a ? res_a : res_b;
		rec.res1  = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rem_q  <= '0;
			acc_q  <= '0;
			mask_q <= '0;
			fill_q <= '0;
			nti_q  <= '0;
		end else if (accept) begin
			pos_q  <= pos_n;
			rem_q  <= rem_n;
			acc_q  <= acc_n;
			mask_q <= mask_n;
			fill_q <= fill_n;
			nti_q  <= nti_n;
		end
	end

endmodule

// ----- rtl/core/bfr_queue.sv -----
module bfr_queue import bfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  bfr_record_t wr_data,
	input  logic        rd_en,
	output bfr_record_t rd_data,
	output logic        full,
	output logic        empty
);

	bfr_record_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en && !full)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en && !empty)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({wr_en && !full, rd_en && !empty})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/bfr_back.sv -----
module bfr_back import bfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bfr_record_t head,
	input  logic        head_empty,
	output logic        head_pop,
	input  logic        pop,
	output bfr_result_t res
);

	logic phase_q;
	logic take;

	assign take     = pop && !head_empty;
	assign res      = phase_q ? head.res1 : head.res0;
	// drop the entry once its last result goes out
	assign head_pop = take && (phase_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= 1'b0;
		else if (take)
			phase_q <= !phase_q && head.two;
	end

endmodule

// ----- rtl/core/bit_field_realigner.sv -----
// Bit field realigner.
// Input channel: push/full carries one source byte (src_byte) per beat, with
// frame_start marking byte 0 of a new source buffer. A beat is taken at a
// clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest target byte sits
// on trg_index, trg_bits, trg_mask and is_last; it leaves on an edge with pop
// high. OR trg_bits into the target buffer under trg_mask.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata write one register per cycle
// (0 src_start_index, 1 src_bit_offset, 2 trg_start_index, 3 trg_bit_offset,
// 4 bit_count); other indexes are ignored.
// A result enters the queue at the edge that takes the byte that finishes it.
// Throughput: one source byte per cycle while full is low; one result per cycle
// while pop is high, so a byte that yields two results holds the result port for
// both. A four-entry queue between the byte classifier and the result serializer
// absorbs that. When the receiver stalls the queue fills and full rises; input
// then holds. Reset clears the configuration, the copy state and the queue; no
// result is produced before the first frame start.
module bit_field_realigner import bfr_pkg::*; #(
	parameter int unsigned BUF_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic [BYTE_W-1:0]     src_byte,
	input  logic                  frame_start,
	output logic                  empty,
	input  logic                  pop,
	output logic [INDEX_W-1:0]    trg_index,
	output logic [BYTE_W-1:0]     trg_bits,
	output logic [BYTE_W-1:0]     trg_mask,
	output logic                  is_last
);

	logic        q_wr_en;
	logic        q_rd_en;
	logic        q_full;
	logic        q_empty;
	logic        accept;
	bfr_record_t rec_in, rec_head;
	bfr_result_t res;

	// accept a beat only when the queue has room for its results
	assign accept = push && !q_full;
	assign full   = q_full;
	assign empty  = q_empty;

	bfr_front #(
		.BUF_BYTES(BUF_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.src_byte   (src_byte),
		.frame_start(frame_start),
		.rec_valid  (q_wr_en),
		.rec        (rec_in)
	);

	bfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr_en),
		.wr_data(rec_in),
		.rd_en  (q_rd_en),
		.rd_data(rec_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// serialize each queue entry into one or two result beats
	bfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rec_head),
		.head_empty(q_empty),
		.head_pop  (q_rd_en),
		.pop       (pop),
		.res       (res)
	);

	assign trg_index = res.trg_index;
	assign trg_bits  = res.trg_bits;
	assign trg_mask  = res.trg_mask;
	assign is_last   = res.is_last;

endmodule
